/* hdl/rve_pkg.sv */
// Shared types, opcodes and constants of the RV32 execute unit.
package rve_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned DIV_STEPS = XLEN;

  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_DIV  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_REM  = 3'd6;
  localparam logic [2:0] F3_BEQ  = 3'd0;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  typedef struct packed {
    logic [31:0]        instruction;
    logic [31:0]        pc;
    logic signed [31:0] rs1_value;
    logic signed [31:0] rs2_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               writes_reg;
    logic [1:0]         memory_op;
    logic               redirect;
    logic [31:0]        next_pc;
  } out_t;

  // Work carried down the pipe: the finished fields plus the
  // multiply/divide operands and their sign fix-up flags.
  typedef struct packed {
    out_t        res;
    logic        use_mul;
    logic        use_div;
    logic        want_rem;
    logic        neg_q;
    logic        neg_r;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] divisor;
  } stage_t;

endpackage

/* hdl/rve_decode.sv */
// Decode, immediate generation and ALU stage, with a registered output.
module rve_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  rve_pkg::in_t    in_item,
  output logic            valid,
  output rve_pkg::stage_t stage
);
  import rve_pkg::*;

  logic [31:0] w, a, b, imm_i, imm_s, imm_b, imm_j, pc4;
  logic [6:0]  op, f7;
  logic [2:0]  f3;
  logic [4:0]  rd;
  stage_t      stage_next;

  assign w     = in_item.instruction;
  assign a     = in_item.rs1_value;
  assign b     = in_item.rs2_value;
  assign op    = w[6:0];
  assign rd    = w[11:7];
  assign f3    = w[14:12];
  assign f7    = w[31:25];
  assign pc4   = in_item.pc + 32'd4;
  assign imm_i = {{20{w[31]}}, w[31:20]};
  assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
  assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};

  always_comb begin
    logic [31:0] opb;
    logic [31:0] jt;
    opb = (op == OP_REG) ? b : imm_i;
    jt  = a + imm_i;
    stage_next = '0;
    stage_next.res.next_pc = pc4;
    stage_next.quo     = a;
    stage_next.divisor = b;
    case (op)
      OP_REG, OP_IMM: begin
        stage_next.res.writes_reg = 1'b1;
        if (op == OP_IMM || f7 == F7_BASE) begin
          case (f3)
            F3_ADD:  stage_next.res.result = a + opb;
            F3_SLL:  stage_next.res.result = a << opb[4:0];
            F3_SLT:  stage_next.res.result = {31'd0, $signed(a) < $signed(opb)};
            F3_SLTU: stage_next.res.result = {31'd0, a < opb};
            F3_SRL:  stage_next.res.result = a >> opb[4:0];
            F3_OR:   stage_next.res.result = a | opb;
            F3_AND:  stage_next.res.result = a & opb;
            default: stage_next.res.result = '0;
          endcase
        end else if (f7 == F7_ALT) begin
          if (f3 == F3_ADD) stage_next.res.result = a - b;
        end else if (f7 == F7_MULDIV) begin
          if (f3 == F3_ADD) begin
            stage_next.use_mul = 1'b1;
          end else if (f3 == F3_DIV || f3 == F3_REM) begin
            if (b == '0) begin
              // Divide by zero: quotient all ones, remainder the dividend.
              stage_next.res.result = (f3 == F3_REM) ? a : '1;
            end else begin
              stage_next.use_div  = 1'b1;
              stage_next.want_rem = (f3 == F3_REM);
              stage_next.neg_q    = a[31] ^ b[31];
              stage_next.neg_r    = a[31];
              stage_next.quo      = a[31] ? 32'd0 - a : a;
              stage_next.divisor  = b[31] ? 32'd0 - b : b;
            end
          end
        end
      end
      OP_LOAD: begin
        stage_next.res.writes_reg = 1'b1;
        stage_next.res.memory_op  = MEM_LOAD;
        stage_next.res.result     = a + imm_i;
      end
      OP_STORE: begin
        stage_next.res.memory_op = MEM_STORE;
        stage_next.res.result    = a + imm_s;
      end
      OP_BRANCH: begin
        stage_next.res.redirect = 1'b1;
        if (f3 == F3_BEQ && a == b) stage_next.res.next_pc = in_item.pc + imm_b;
      end
      OP_LUI: begin
        stage_next.res.writes_reg = 1'b1;
        stage_next.res.result     = {w[31:12], 12'd0};
      end
      OP_JAL: begin
        stage_next.res.writes_reg = 1'b1;
        stage_next.res.redirect   = 1'b1;
        stage_next.res.result     = pc4;
        stage_next.res.next_pc    = in_item.pc + imm_j;
      end
      OP_JALR: begin
        stage_next.res.writes_reg = 1'b1;
        stage_next.res.redirect   = 1'b1;
        stage_next.res.result     = pc4;
        stage_next.res.next_pc    = {jt[31:1], 1'b0};
      end
      default: stage_next.res.result = '0;
    endcase
    if (rd == 5'd0) stage_next.res.writes_reg = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else     valid <= start;
    stage <= stage_next;
  end

endmodule

/* hdl/rve_div_step.sv */
// One registered restoring-division step: one quotient bit per stage.
module rve_div_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid_in,
  input  rve_pkg::stage_t stage_in,
  output logic            valid,
  output rve_pkg::stage_t stage
);
  import rve_pkg::*;

  logic [32:0] shifted, diff;
  stage_t      stage_next;

  assign shifted = {stage_in.rem, stage_in.quo[31]};
  assign diff    = shifted - {1'b0, stage_in.divisor};

  always_comb begin
    stage_next = stage_in;
    if (stage_in.use_div) begin
      stage_next.rem = diff[32] ? shifted[31:0] : diff[31:0];
      stage_next.quo = {stage_in.quo[30:0], ~diff[32]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else     valid <= valid_in;
    stage <= stage_next;
  end

endmodule

/* hdl/rv32_execute_unit.sv */
// Top level of the pipelined RV32 execute unit.
//
// Usage: present one instruction transaction on in_item and raise start for
// one cycle. busy is held low, so a transaction is taken on every cycle
// that start is high; transactions may follow back to back.
// Each transaction gives exactly one result on out_item, marked by done for
// exactly one cycle, in the order the transactions were taken.
// Stages, for every instruction: decode/ALU (1), multiply (1), 32 division
// steps (one quotient bit per stage), output select (1). The 32-stage
// restoring divider sets the depth; every instruction walks it so results
// keep order. Throughput: one transaction per cycle.
// Reset (rst, synchronous) clears all stage valid bits; transactions in
// flight are dropped and no done follows. The receiver cannot stall: each
// result must be taken in the cycle done is high.
module rv32_execute_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  rve_pkg::in_t  in_item,
  output logic          done,
  output rve_pkg::out_t out_item
);
  import rve_pkg::*;

  logic   dec_valid, mul_valid;
  stage_t dec_stage, mul_stage;
  stage_t mul_next;
  logic   vld [0:DIV_STEPS];
  stage_t stg [0:DIV_STEPS];
  logic [31:0] q_fix, r_fix;
  out_t   out_next;

  // Never hold off the sender: every stage advances each cycle.
  assign busy = 1'b0;

  rve_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .in_item (in_item),
    .valid   (dec_valid),
    .stage   (dec_stage)
  );

  // Multiply stage: low word of the product, registered before the divider.
  always_comb begin
    mul_next = dec_stage;
    if (dec_stage.use_mul) mul_next.res.result = dec_stage.quo * dec_stage.divisor;
  end

  always_ff @(posedge clk) begin
    if (rst) mul_valid <= 1'b0;
    else     mul_valid <= dec_valid;
    mul_stage <= mul_next;
  end

  assign vld[0] = mul_valid;
  assign stg[0] = mul_stage;

  // Divider chain: each stage resolves one quotient bit.
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    rve_div_step u_step (
      .clk      (clk),
      .rst      (rst),
      .valid_in (vld[i]),
      .stage_in (stg[i]),
      .valid    (vld[i+1]),
      .stage    (stg[i+1])
    );
  end

  // Apply signs of the operands to the magnitude quotient and remainder.
  assign q_fix = stg[DIV_STEPS].neg_q ? 32'd0 - stg[DIV_STEPS].quo : stg[DIV_STEPS].quo;
  assign r_fix = stg[DIV_STEPS].neg_r ? 32'd0 - stg[DIV_STEPS].rem : stg[DIV_STEPS].rem;

  always_comb begin
    out_next = stg[DIV_STEPS].res;
    if (stg[DIV_STEPS].use_div) begin
      out_next.result = stg[DIV_STEPS].want_rem ? r_fix : q_fix;
    end
  end

  // Output register: done strobes for one cycle per result.
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vld[DIV_STEPS];
    out_item <= out_next;
  end

`ifndef SYNTHESIS
  a_no_redirect_mem: assert property (@(posedge clk) disable iff (rst)
    done |-> !(out_item.redirect && out_item.memory_op != MEM_NONE))
    else $error("redirect with memory operation");
  a_store_no_write: assert property (@(posedge clk) disable iff (rst)
    (done && out_item.memory_op == MEM_STORE) |-> !out_item.writes_reg)
    else $error("store writes a register");
  a_mem_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_item.memory_op == MEM_NONE || out_item.memory_op == MEM_LOAD ||
              out_item.memory_op == MEM_STORE))
    else $error("bad memory operation code");
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (vld[DIV_STEPS] && !rst) |=> done)
    else $error("result dropped at output");
`endif

endmodule

/* tb/sv/rv32_execute_unit_tb.sv */
// Testbench for the RV32 execute unit: directed and random instructions checked against a predictor.
`timescale 1ns / 1ps

module rv32_execute_unit_tb;
  import rve_pkg::*;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  logic  busy;
  in_t   in_item = '0;
  logic  done;
  out_t  out_item;

  // Expected results, oldest first; the block keeps transactions in order.
  out_t  expected_q[$];
  int    error_count = 0;
  int    gap_pct = 0;
  int    pending_idle = 0;

  rv32_execute_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .done     (done),
    .out_item (out_item)
  );

  always #1 clk = ~clk;

  // Sign-extended immediates of the I, S, B and J forms.
  function automatic logic [31:0] imm_i(input logic [31:0] w);
    return {{20{w[31]}}, w[31:20]};
  endfunction

  function automatic logic [31:0] imm_s(input logic [31:0] w);
    return {{20{w[31]}}, w[31:25], w[11:7]};
  endfunction

  function automatic logic [31:0] imm_b(input logic [31:0] w);
    return {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  endfunction

  function automatic logic [31:0] imm_j(input logic [31:0] w);
    return {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  endfunction

  // Signed divide or remainder with the RISC-V corner rules.
  function automatic logic [31:0] signed_divrem(input logic [31:0] a, input logic [31:0] b,
                                                input bit want_rem);
    logic [31:0] ma, mb, q, r;
    if (b == 32'd0) return want_rem ? a : 32'hFFFF_FFFF;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = ma / mb;
    r  = ma % mb;
    if (a[31] != b[31]) q = -q;
    if (a[31]) r = -r;
    return want_rem ? r : q;
  endfunction

  // Shared ALU for the register and immediate forms.
  function automatic logic [31:0] alu_value(input logic [2:0] f3, input logic [31:0] a,
                                            input logic [31:0] b);
    case (f3)
      F3_ADD:  return a + b;
      F3_SLL:  return a << b[4:0];
      F3_SLT:  return {31'd0, $signed(a) < $signed(b)};
      F3_SLTU: return {31'd0, a < b};
      F3_SRL:  return a >> b[4:0];
      F3_OR:   return a | b;
      F3_AND:  return a & b;
      default: return 32'd0;
    endcase
  endfunction

  function automatic out_t execute_instruction(input in_t it);
    out_t        o;
    logic [31:0] w, a, b, pc;
    logic [6:0]  f7;
    logic [2:0]  f3;
    w  = it.instruction;
    pc = it.pc;
    a  = it.rs1_value;
    b  = it.rs2_value;
    f7 = w[31:25];
    f3 = w[14:12];
    o = '0;
    o.next_pc = pc + 32'd4;
    case (w[6:0])
      OP_REG: begin
        o.writes_reg = 1'b1;
        if (f7 == F7_BASE) begin
          o.result = alu_value(f3, a, b);
        end else if (f7 == F7_ALT) begin
          if (f3 == F3_ADD) o.result = a - b;
        end else if (f7 == F7_MULDIV) begin
          if (f3 == F3_ADD) o.result = a * b;
          else if (f3 == F3_DIV) o.result = signed_divrem(a, b, 1'b0);
          else if (f3 == F3_REM) o.result = signed_divrem(a, b, 1'b1);
        end
      end
      OP_IMM: begin
        o.writes_reg = 1'b1;
        o.result = alu_value(f3, a, imm_i(w));
      end
      OP_LOAD: begin
        o.writes_reg = 1'b1;
        o.memory_op = MEM_LOAD;
        o.result = a + imm_i(w);
      end
      OP_STORE: begin
        o.memory_op = MEM_STORE;
        o.result = a + imm_s(w);
      end
      OP_BRANCH: begin
        o.redirect = 1'b1;
        if (f3 == F3_BEQ && a == b) o.next_pc = pc + imm_b(w);
      end
      OP_LUI: begin
        o.writes_reg = 1'b1;
        o.result = {w[31:12], 12'd0};
      end
      OP_JAL: begin
        o.writes_reg = 1'b1;
        o.redirect = 1'b1;
        o.result = pc + 32'd4;
        o.next_pc = pc + imm_j(w);
      end
      OP_JALR: begin
        o.writes_reg = 1'b1;
        o.redirect = 1'b1;
        o.result = pc + 32'd4;
        o.next_pc = (a + imm_i(w)) & ~32'd1;
      end
      default: ;
    endcase
    if (w[11:7] == 5'd0) o.writes_reg = 1'b0;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  // Send one transaction, with a random idle gap ahead of it.
  // start stays high after the transaction; the next gap or the caller drops it.
  task automatic send_instruction(input in_t it);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(execute_instruction(it));
  endtask

  // Check every result as it leaves; the receiver cannot stall.
  always @(posedge clk) begin
    out_t want;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_item.result, 32'd0);
      end else begin
        want = expected_q.pop_front();
        if (out_item.result !== want.result)
          report_mismatch("result", out_item.result, want.result);
        if (out_item.writes_reg !== want.writes_reg)
          report_mismatch("writes_reg", 32'(out_item.writes_reg), 32'(want.writes_reg));
        if (out_item.memory_op !== want.memory_op)
          report_mismatch("memory_op", 32'(out_item.memory_op), 32'(want.memory_op));
        if (out_item.redirect !== want.redirect)
          report_mismatch("redirect", 32'(out_item.redirect), 32'(want.redirect));
        if (out_item.next_pc !== want.next_pc)
          report_mismatch("next_pc", out_item.next_pc, want.next_pc);
      end
    end
  end

  function automatic logic [31:0] edge_value();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'd1;
      5: return $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] make_r(input logic [6:0] f7, input logic [2:0] f3);
    logic [31:0] w;
    w = $urandom;
    w[31:25] = f7;
    w[14:12] = f3;
    w[6:0]   = OP_REG;
    return w;
  endfunction

  function automatic in_t make_item(input logic [31:0] w, input logic [31:0] a,
                                    input logic [31:0] b);
    in_t it;
    it.instruction = w;
    it.pc = $urandom;
    it.rs1_value = a;
    it.rs2_value = b;
    return it;
  endfunction

  // Corner cases: field extremes, divide corners, each opcode and rd of zero.
  task automatic test_directed();
    logic [6:0] ops[8];
    logic [31:0] w;
    ops = '{OP_REG, OP_IMM, OP_LOAD, OP_STORE, OP_BRANCH, OP_LUI, OP_JAL, OP_JALR};
    send_instruction('0);
    send_instruction('1);
    send_instruction(make_item(make_r(F7_MULDIV, F3_DIV), 32'h1234, 32'd0));
    send_instruction(make_item(make_r(F7_MULDIV, F3_REM), 32'h8765_4321, 32'd0));
    send_instruction(make_item(make_r(F7_MULDIV, F3_DIV), 32'h8000_0000, 32'hFFFF_FFFF));
    send_instruction(make_item(make_r(F7_MULDIV, F3_REM), 32'h8000_0000, 32'hFFFF_FFFF));
    send_instruction(make_item(make_r(F7_MULDIV, F3_ADD), 32'hFFFF_FFFF, 32'h8000_0000));
    send_instruction(make_item(make_r(F7_ALT, F3_ADD), 32'h8000_0000, 32'd1));
    // Addi with bit 30 set still adds.
    w = {12'h400, 5'd3, F3_ADD, 5'd5, OP_IMM};
    send_instruction(make_item(w, 32'd10, 32'd0));
    // Beq taken with the most negative offset.
    w = {1'b1, 6'd0, 5'd2, 5'd1, F3_BEQ, 4'd0, 1'b0, OP_BRANCH};
    send_instruction(make_item(w, 32'h55, 32'h55));
    // Unknown opcode.
    send_instruction(make_item(32'hFFFF_FF7F, 32'd1, 32'd2));
    foreach (ops[i]) begin
      w = $urandom;
      w[6:0] = ops[i];
      w[11:7] = 5'd0;
      send_instruction(make_item(w, edge_value(), edge_value()));
    end
  endtask

  // Mostly legal encodings of listed operations with random content.
  task automatic test_random(input int count);
    logic [6:0]  ops[8];
    logic [6:0]  f7s[3];
    logic [31:0] w, a, b;
    ops = '{OP_REG, OP_IMM, OP_LOAD, OP_STORE, OP_BRANCH, OP_LUI, OP_JAL, OP_JALR};
    f7s = '{F7_BASE, F7_ALT, F7_MULDIV};
    repeat (count) begin
      w = $urandom;
      if ($urandom_range(9) != 0) w[6:0] = ops[$urandom_range(7)];
      if (w[6:0] == OP_REG && $urandom_range(9) != 0) w[31:25] = f7s[$urandom_range(2)];
      a = edge_value();
      b = $urandom_range(3) == 0 ? a : edge_value();
      if (w[6:0] == OP_BRANCH && $urandom_range(1)) w[14:12] = F3_BEQ;
      send_instruction(make_item(w, a, b));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    gap_pct = 7;
    test_directed();
    test_random(260);
    gap_pct = 54;
    test_random(260);
    gap_pct = 0;
    test_random(280);
    start <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    // Catch any stray result.
    repeat (40) @(posedge clk);
    if (error_count == 0)
      $display("rv32_execute_unit_tb: PASS");
    else
      $display("rv32_execute_unit_tb: FAIL");
    $finish;
  end

  initial begin
    #200000;
    $display("rv32_execute_unit_tb: FAIL");
    $finish;
  end

endmodule
